[hw/rtl/sha1_message_hash_top_defines.svh]
// ----------------------------------------------------------------------------
// SHA-1 message hash: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_HASH_TOP_DEFINES_SVH
`define SHA1_MESSAGE_HASH_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SHA1H_CHECK_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHA1H_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sha1h_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 message hash: shared package
// Word and digest types, round constants, and the round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1h_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [4:0][31:0] hash_type;
   typedef logic [3:0]       addr_type;
   typedef logic [6:0]       round_type;

   // Control from the sequencer to the round datapath.
   typedef struct packed {
      logic      init;   // reload chain with the initial hash
      logic      load;   // copy chain into the working variables
      logic      step;   // run one round
      logic      fold;   // add working variables into the chain
      round_type rnd;    // current round number
   } ctrl_type;

   localparam hash_type InitHash = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                    32'hefcdab89, 32'h67452301};

   localparam round_type SchedRounds = 7'd16;
   localparam round_type LastRound   = 7'd79;
   localparam logic [7:0] PadByte    = 8'h80;

   function automatic word_type round_k(input round_type t);
      word_type k;
      if (t < 7'd20) begin
         k = 32'h5A827999;
      end else if (t < 7'd40) begin
         k = 32'h6ED9EBA1;
      end else if (t < 7'd60) begin
         k = 32'h8F1BBCDC;
      end else begin
         k = 32'hCA62C1D6;
      end
      return k;
   endfunction

   function automatic word_type round_f(input round_type t, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      if (t < 7'd20) begin
         f = d ^ (b & (c ^ d));
      end else if (t < 7'd40) begin
         f = b ^ c ^ d;
      end else if (t < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/sha1_message_hash_top.sv]
// Sequence: a finish beat runs the pad byte, zero fill, length words and
//   compression before the first digest word shows; pad overflow compresses an extra block first.
// Throughput: append beats are taken one per cycle while idle; every 64th byte
//   stalls the input while the block compresses (one round per cycle).
// Reset: synchronous, active high; restores the initial hash, clears the
//   byte count and returns to idle. Schedule memory contents need no reset.
// ----------------------------------------------------------------------------
// SHA-1 message hash: top level
// Byte packing, padding sequencer, compression control and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_message_hash_top_defines.svh"

module sha1_message_hash_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_mode,
   input  wire logic [7:0]  req_data_byte,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   // One-hot sequencer states.
   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_PAD     = 9'b000000010,
      S_ZERO    = 9'b000000100,
      S_LEN_HI  = 9'b000001000,
      S_LEN_LO  = 9'b000010000,
      S_C_PREP  = 9'b000100000,
      S_C_ROUND = 9'b001000000,
      S_C_FOLD  = 9'b010000000,
      S_OUT     = 9'b100000000
   } state_type;

   // Where to go once a compression has folded into the chain.
   typedef enum logic [1:0] {
      RET_IDLE   = 2'd0,
      RET_REFILL = 2'd1,
      RET_OUT    = 2'd2
   } ret_type;

   state_type             state_ff, state_in;
   ret_type               ret_ff, ret_in;
   logic [60:0]           cnt_ff, cnt_in;      // message length in bytes
   sha1h_pkg::word_type   acc_ff, acc_in;      // partial word being packed
   sha1h_pkg::round_type  t_ff, t_in;          // round counter
   logic [4:0]            ptr_ff, ptr_in;      // zero fill pointer
   logic [4:0]            end_ff, end_in;      // zero fill stop (exclusive)
   logic                  ovf_ff, ovf_in;      // pad spills into an extra block
   logic [2:0]            idx_ff, idx_in;      // digest word being shown

   // Memory write port and read addresses.
   logic                  mem_we;
   sha1h_pkg::addr_type   mem_waddr;
   sha1h_pkg::word_type   mem_wdata;
   sha1h_pkg::addr_type   rd_round;
   sha1h_pkg::addr_type   ra_cur, ra_p2, ra_p8, ra_p13;
   sha1h_pkg::word_type   rd_cur, rd_p2, rd_p8, rd_p13;

   sha1h_pkg::ctrl_type   ctrl;
   sha1h_pkg::word_type   sched_word;
   sha1h_pkg::hash_type   chain;

   logic                  req_fire;
   logic                  rsp_fire;
   sha1h_pkg::addr_type   word_pos;
   logic [1:0]            byte_pos;
   logic [4:0]            shamt;
   sha1h_pkg::word_type   byte_placed;
   sha1h_pkg::word_type   pad_word;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_fire  = rsp_valid & ~rsp_stall;

   // Output payload comes straight from the chain registers, which hold
   // still for as long as the sequencer sits in the output state.
   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd4);

   // ------------------------------------------------------------------------
   // Byte placement: big-endian within each word
   // ------------------------------------------------------------------------
   assign word_pos    = cnt_ff[5:2];
   assign byte_pos    = cnt_ff[1:0];
   assign shamt       = {~byte_pos, 3'b000};
   assign byte_placed = 32'(req_data_byte) << shamt;
   assign pad_word    = acc_ff | (32'(sha1h_pkg::PadByte) << shamt);

   // ------------------------------------------------------------------------
   // Schedule read addresses: always prefetch the words of the next round
   // so that registered read data lines up with the round that uses it.
   // ------------------------------------------------------------------------
   assign rd_round = (state_ff == S_C_PREP) ? 4'd0 : (t_ff[3:0] + 4'd1);
   assign ra_cur   = rd_round;
   assign ra_p2    = rd_round + 4'd2;
   assign ra_p8    = rd_round + 4'd8;
   assign ra_p13   = rd_round + 4'd13;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      t_in      = t_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      mem_we    = 1'b0;
      mem_waddr = word_pos;
      mem_wdata = '0;

      ctrl      = '0;
      ctrl.rnd  = t_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_mode) begin
                  state_in = S_PAD;
               end else begin
                  // Pack the byte; flush the word once it is full.
                  cnt_in = cnt_ff + 61'd1;
                  if (byte_pos == 2'd3) begin
                     mem_we    = 1'b1;
                     mem_waddr = word_pos;
                     mem_wdata = acc_ff | byte_placed;
                     acc_in    = '0;
                  end else begin
                     acc_in = acc_ff | byte_placed;
                  end
                  if (cnt_ff[5:0] == 6'd63) begin
                     ret_in   = RET_IDLE;
                     state_in = S_C_PREP;
                  end
               end
            end
         end

         S_PAD: begin
            // Drop the pad byte behind the last data byte, then zero-fill.
            mem_we    = 1'b1;
            mem_waddr = word_pos;
            mem_wdata = pad_word;
            ptr_in    = {1'b0, word_pos} + 5'd1;
            ovf_in    = (word_pos >= 4'd14);
            end_in    = (word_pos >= 4'd14) ? 5'd16 : 5'd14;
            state_in  = S_ZERO;
         end

         S_ZERO: begin
            if (ptr_ff == end_ff) begin
               if (ovf_ff) begin
                  ret_in   = RET_REFILL;
                  state_in = S_C_PREP;
               end else begin
                  state_in = S_LEN_HI;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff[3:0];
               mem_wdata = '0;
               ptr_in    = ptr_ff + 5'd1;
            end
         end

         S_LEN_HI: begin
            mem_we    = 1'b1;
            mem_waddr = 4'd14;
            mem_wdata = cnt_ff[60:29];
            state_in  = S_LEN_LO;
         end

         S_LEN_LO: begin
            mem_we    = 1'b1;
            mem_waddr = 4'd15;
            mem_wdata = {cnt_ff[28:0], 3'b000};
            ret_in    = RET_OUT;
            state_in  = S_C_PREP;
         end

         S_C_PREP: begin
            ctrl.load = 1'b1;
            t_in      = 7'd0;
            state_in  = S_C_ROUND;
         end

         S_C_ROUND: begin
            // Write the expanded schedule word back into its slot.
            ctrl.step = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = t_ff[3:0];
            mem_wdata = sched_word;
            if (t_ff == sha1h_pkg::LastRound) begin
               state_in = S_C_FOLD;
            end else begin
               t_in = t_ff + 7'd1;
            end
         end

         S_C_FOLD: begin
            ctrl.fold = 1'b1;
            case (ret_ff)
               RET_IDLE: begin
                  state_in = S_IDLE;
               end
               RET_REFILL: begin
                  // Extra block: zeros up to the length words.
                  ptr_in   = 5'd0;
                  end_in   = 5'd14;
                  ovf_in   = 1'b0;
                  state_in = S_ZERO;
               end
               RET_OUT: begin
                  idx_in   = 3'd0;
                  state_in = S_OUT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_OUT: begin
            if (rsp_fire) begin
               if (idx_ff == 3'd4) begin
                  // Last beat taken: restart for a new message.
                  ctrl.init = 1'b1;
                  cnt_in    = '0;
                  acc_in    = '0;
                  state_in  = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= RET_IDLE;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         t_ff     <= '0;
         ptr_ff   <= '0;
         end_ff   <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         t_ff     <= t_in;
         ptr_ff   <= ptr_in;
         end_ff   <= end_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
      end
   end

   // ------------------------------------------------------------------------
   // Schedule memories: two identical copies, two read ports each, so that
   // the four taps of the rolling schedule are all read in the same cycle.
   // ------------------------------------------------------------------------
   sha1h_wmem u_wmem_lo (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_waddr),
      .wr_data  (mem_wdata),
      .rd_addr0 (ra_cur),
      .rd_addr1 (ra_p2),
      .rd_data0 (rd_cur),
      .rd_data1 (rd_p2)
   );

   sha1h_wmem u_wmem_hi (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_waddr),
      .wr_data  (mem_wdata),
      .rd_addr0 (ra_p8),
      .rd_addr1 (ra_p13),
      .rd_data0 (rd_p8),
      .rd_data1 (rd_p13)
   );

   // ------------------------------------------------------------------------
   // Round datapath and chain hash
   // ------------------------------------------------------------------------
   sha1h_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .rd_cur     (rd_cur),
      .rd_p2      (rd_p2),
      .rd_p8      (rd_p8),
      .rd_p13     (rd_p13),
      .sched_word (sched_word),
      .chain      (chain)
   );

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   `SHA1H_CHECK_NOW(a_take_only_quiet, clock, reset, !req_stall, !rsp_valid,
      "request taken while digest beats are pending")

   `SHA1H_CHECK_NOW(a_round_range, clock, reset, state_ff == S_C_ROUND,
      t_ff <= sha1h_pkg::LastRound, "round counter past the last round")

   `SHA1H_CHECK_NEXT(a_full_block, clock, reset,
      req_fire && !req_mode && cnt_ff[5:0] == 6'd63, state_ff == S_C_PREP,
      "full block did not start a compression")

   `SHA1H_CHECK_NEXT(a_restart, clock, reset, rsp_fire && rsp_last_word,
      cnt_ff == '0 && state_ff == S_IDLE, "no restart after the last digest beat")

endmodule

`default_nettype wire

[hw/rtl/sha1h_wmem.sv]
// ----------------------------------------------------------------------------
// SHA-1 message hash: schedule memory
// Sixteen-word synchronous memory, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1h_wmem (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire sha1h_pkg::addr_type wr_addr,
   input  wire sha1h_pkg::word_type wr_data,
   input  wire sha1h_pkg::addr_type rd_addr0,
   input  wire sha1h_pkg::addr_type rd_addr1,
   output sha1h_pkg::word_type      rd_data0,
   output sha1h_pkg::word_type      rd_data1
);

   sha1h_pkg::word_type mem_ff [16];
   sha1h_pkg::word_type rd0_ff;
   sha1h_pkg::word_type rd1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd0_ff <= mem_ff[rd_addr0];
      rd1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

`default_nettype wire

[hw/rtl/sha1h_round.sv]
// ----------------------------------------------------------------------------
// SHA-1 message hash: round datapath
// Working variables, chain hash, schedule expansion and one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1h_round (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sha1h_pkg::ctrl_type ctrl,
   input  wire sha1h_pkg::word_type rd_cur,   // schedule word t
   input  wire sha1h_pkg::word_type rd_p2,    // schedule word t+2 (mod 16)
   input  wire sha1h_pkg::word_type rd_p8,    // schedule word t+8 (mod 16)
   input  wire sha1h_pkg::word_type rd_p13,   // schedule word t+13 (mod 16)
   output sha1h_pkg::word_type      sched_word,
   output sha1h_pkg::hash_type      chain
);

   sha1h_pkg::hash_type work_ff;
   sha1h_pkg::hash_type work_in;
   sha1h_pkg::hash_type chain_ff;
   sha1h_pkg::hash_type chain_in;

   sha1h_pkg::word_type mix;
   sha1h_pkg::word_type w;
   sha1h_pkg::word_type temp;

   always_comb begin
      mix = rd_p13 ^ rd_p8 ^ rd_p2 ^ rd_cur;
      if (ctrl.rnd < sha1h_pkg::SchedRounds) begin
         w = rd_cur;
      end else begin
         w = {mix[30:0], mix[31]};
      end
      temp = {work_ff[0][26:0], work_ff[0][31:27]}
           + sha1h_pkg::round_f(ctrl.rnd, work_ff[1], work_ff[2], work_ff[3])
           + work_ff[4] + sha1h_pkg::round_k(ctrl.rnd) + w;
   end

   always_comb begin
      work_in = work_ff;
      if (ctrl.load) begin
         work_in = chain_ff;
      end else if (ctrl.step) begin
         work_in[0] = temp;
         work_in[1] = work_ff[0];
         work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctrl.init) begin
         chain_in = sha1h_pkg::InitHash;
      end else if (ctrl.fold) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha1h_pkg::InitHash;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign sched_word = w;
   assign chain      = chain_ff;

endmodule

`default_nettype wire
